[hw/rtl/sll_pkg.sv]
`timescale 1ns / 1ps

package sll_pkg;

    // default sizes of the node store
    localparam int NODES_DEF      = 256;
    localparam int VALUE_BITS_DEF = 32;

    // stream word widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // operation codes, codes 5 to 7 do nothing
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_GET    = 3'd2,
        OP_LOCATE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BADPOS   = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // one result word as it leaves the sequencer
    typedef struct packed {
        logic [7:0]  list_length;
        logic [7:0]  found_position;
        logic [31:0] result_value;
        t_status     status;
    } t_result;

endpackage

[hw/rtl/static_linked_list_engine.sv]
`timescale 1ns / 1ps

// Ordered list of values in a fixed store of NODES nodes, with unused nodes
// on a free list; nodes 1 to NODES-2 hold data. Each input word carries one
// operation in tuser (insert, delete, get, locate, clear) and yields exactly
// one output word with status and the new length. Links and values sit in
// two single-port-read memories with a registered read, so each step along
// the list passes through a wait state and a move state. Get, insert and
// delete walk the list from the head; locate checks entries in order until
// a hit. Clear and rejected requests go straight to the result. Items are
// handled one at a time; a finished word waits in the output register while
// the next is taken.
// Reset and clear take effect at once: never-used nodes are tracked by a
// fill mark instead of a sweep over the link memory.
module static_linked_list_engine
    import sll_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // position [7:0], item_value [39:8]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // opcode [2:0]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // result_value [31:0], found_position [39:32], list_length [47:40]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // status [1:0]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int IDX_W = $clog2(NODES);

    logic                  w_res_valid;
    logic                  w_res_ready;
    t_result               w_res;
    logic [IDX_W-1:0]      w_raddr;
    logic [IDX_W-1:0]      w_link_q;
    logic [VALUE_BITS-1:0] w_value_q;
    logic                  w_link_we;
    logic [IDX_W-1:0]      w_link_waddr;
    logic [IDX_W-1:0]      w_link_wdata;
    logic                  w_value_we;
    logic [IDX_W-1:0]      w_value_waddr;
    logic [VALUE_BITS-1:0] w_value_wdata;

    // operation sequencer with list headers
    sll_seq #(
        .NODES      (NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_opcode      (i_s_axis_tuser[2:0]),
        .i_position    (i_s_axis_tdata[7:0]),
        .i_item_value  (i_s_axis_tdata[39:8]),
        .o_res_valid   (w_res_valid),
        .i_res_ready   (w_res_ready),
        .o_res         (w_res),
        .o_raddr       (w_raddr),
        .i_link_q      (w_link_q),
        .i_value_q     (w_value_q),
        .o_link_we     (w_link_we),
        .o_link_waddr  (w_link_waddr),
        .o_link_wdata  (w_link_wdata),
        .o_value_we    (w_value_we),
        .o_value_waddr (w_value_waddr),
        .o_value_wdata (w_value_wdata)
    );

    // link store
    sll_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NODES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_link_q)
    );

    // value store
    sll_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_value_we),
        .i_waddr (w_value_waddr),
        .i_wdata (w_value_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_value_q)
    );

    // output word register
    sll_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (w_res_valid),
        .o_res_ready     (w_res_ready),
        .i_res           (w_res),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

`ifndef ASSERT_OFF
    // a result handed to the output register shows up on the next cycle
    a_res_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> o_m_axis_tvalid)
        else $error("result word lost on its way to the output");

    // a new request is never taken while a result is still pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> !w_res_valid)
        else $error("request taken while a result is pending");

    // a rejected position reports no value and no position
    a_badpos_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_BADPOS)) |->
        (o_m_axis_tdata[39:0] == 40'd0))
        else $error("bad position word carries data");

    // a found position comes only with an ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[39:32] != 8'd0)) |->
        (o_m_axis_tuser == ST_OK))
        else $error("found position with a failing status");
`endif

endmodule

[hw/rtl/sll_ram.sv]
`timescale 1ns / 1ps

module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read every cycle (read-first)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/sll_seq.sv]
`timescale 1ns / 1ps

module sll_seq
    import sll_pkg::*;
#(
    parameter int NODES      = NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request side
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [2:0]               i_opcode,
    input  logic [7:0]               i_position,
    input  logic [31:0]              i_item_value,
    // result side
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output t_result                  o_res,
    // shared read address of both stores
    output logic [$clog2(NODES)-1:0] o_raddr,
    input  logic [$clog2(NODES)-1:0] i_link_q,
    input  logic [VALUE_BITS-1:0]    i_value_q,
    // link store write port
    output logic                     o_link_we,
    output logic [$clog2(NODES)-1:0] o_link_waddr,
    output logic [$clog2(NODES)-1:0] o_link_wdata,
    // value store write port
    output logic                     o_value_we,
    output logic [$clog2(NODES)-1:0] o_value_waddr,
    output logic [VALUE_BITS-1:0]    o_value_wdata
);

    localparam int IDX_W = $clog2(NODES);
    localparam int CMP_W = ((IDX_W > 8) ? IDX_W : 8) + 1;
    localparam logic [IDX_W-1:0] LAST_USABLE = IDX_W'(NODES - 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_A,
        S_POP_B,
        S_WALK_A,
        S_WALK_B,
        S_AT,
        S_INS_LINK,
        S_DEL_A,
        S_DEL_B,
        S_DEL_C,
        S_LOC_A,
        S_LOC_B,
        S_DONE
    } t_state;

    t_state                r_state;
    t_opcode               r_op;
    logic [7:0]            r_pos;
    logic [VALUE_BITS-1:0] r_val;
    logic [IDX_W-1:0]      r_node;
    logic [IDX_W-1:0]      r_new;
    logic [IDX_W-1:0]      r_prev;
    logic [IDX_W-1:0]      r_tmp;
    logic [IDX_W-1:0]      r_steps;
    logic [IDX_W-1:0]      r_k;
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_free;
    logic [IDX_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      r_fcnt;
    logic [IDX_W-1:0]      r_fresh;
    t_status               r_status;
    logic [VALUE_BITS-1:0] r_rval;
    logic [IDX_W-1:0]      r_fpos;

    logic [63:0]      w_val_ext;
    logic [63:0]      w_rval_ext;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_rpos_x;
    logic [CMP_W-1:0] w_cnt_x;
    logic [CMP_W-1:0] w_fpos_x;
    logic             w_ins_ok;
    logic             w_pos_ok;
    logic [IDX_W-1:0] w_link;

    // value of the item, sign extended to the store width
    assign w_val_ext = {{32{i_item_value[31]}}, i_item_value};

    // position range checks against the current length
    assign w_pos_x  = CMP_W'(i_position);
    assign w_rpos_x = CMP_W'(r_pos);
    assign w_cnt_x  = CMP_W'(r_cnt);
    assign w_ins_ok = (i_position != 8'd0) && (w_pos_x <= w_cnt_x + CMP_W'(1));
    assign w_pos_ok = (i_position != 8'd0) && (w_pos_x <= w_cnt_x);

    // link of the node read last cycle; nodes at or below the fresh mark
    // were never written since reset or clear and stand for a descending chain
    always_comb begin
        if (r_node == '0) begin
            w_link = '0;
        end else if (r_node <= r_fresh) begin
            w_link = r_node - IDX_W'(1);
        end else begin
            w_link = i_link_q;
        end
    end

    assign o_raddr = r_node;

    // store write ports
    always_comb begin
        o_link_we     = 1'b0;
        o_link_waddr  = r_node;
        o_link_wdata  = r_new;
        o_value_we    = 1'b0;
        o_value_waddr = r_node;
        o_value_wdata = r_val;
        case (r_state)
            S_POP_B: begin
                o_value_we = 1'b1;
            end
            S_AT: begin
                o_link_we = (r_op == OP_INSERT);
            end
            S_INS_LINK: begin
                o_link_we    = 1'b1;
                o_link_waddr = r_new;
                o_link_wdata = r_tmp;
            end
            S_DEL_B: begin
                o_link_we    = (r_pos != 8'd1);
                o_link_waddr = r_prev;
                o_link_wdata = w_link;
            end
            S_DEL_C: begin
                o_link_we    = 1'b1;
                o_link_wdata = r_free;
            end
            default: begin
                o_link_we = 1'b0;
            end
        endcase
    end

    // operation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_free  <= LAST_USABLE;
            r_cnt   <= '0;
            r_fcnt  <= LAST_USABLE;
            r_fresh <= LAST_USABLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= t_opcode'(i_opcode);
                        r_pos    <= i_position;
                        r_val    <= w_val_ext[VALUE_BITS-1:0];
                        r_status <= ST_OK;
                        r_rval   <= '0;
                        r_fpos   <= '0;
                        case (t_opcode'(i_opcode))
                            OP_INSERT: begin
                                if (!w_ins_ok) begin
                                    r_status <= ST_BADPOS;
                                    r_state  <= S_DONE;
                                end else if (r_fcnt == '0) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_node  <= r_free;
                                    r_state <= S_POP_A;
                                end
                            end
                            OP_DELETE: begin
                                if (!w_pos_ok) begin
                                    r_status <= ST_BADPOS;
                                    r_state  <= S_DONE;
                                end else if (i_position == 8'd1) begin
                                    r_node  <= r_head;
                                    r_state <= S_DEL_A;
                                end else begin
                                    r_node  <= r_head;
                                    r_steps <= IDX_W'(w_pos_x - CMP_W'(2));
                                    r_state <= S_WALK_A;
                                end
                            end
                            OP_GET: begin
                                if (!w_pos_ok) begin
                                    r_status <= ST_BADPOS;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_node  <= r_head;
                                    r_steps <= IDX_W'(w_pos_x - CMP_W'(1));
                                    r_state <= S_WALK_A;
                                end
                            end
                            OP_LOCATE: begin
                                r_node  <= r_head;
                                r_k     <= IDX_W'(1);
                                r_state <= S_LOC_A;
                            end
                            OP_CLEAR: begin
                                r_head  <= '0;
                                r_free  <= LAST_USABLE;
                                r_cnt   <= '0;
                                r_fcnt  <= LAST_USABLE;
                                r_fresh <= LAST_USABLE;
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // wait for the free head's link
                S_POP_A: begin
                    r_state <= S_POP_B;
                end
                // take the free head as the new node
                S_POP_B: begin
                    r_new  <= r_node;
                    r_free <= w_link;
                    r_fcnt <= r_fcnt - IDX_W'(1);
                    if (r_node <= r_fresh) begin
                        r_fresh <= r_node - IDX_W'(1);
                    end
                    if (r_pos == 8'd1) begin
                        r_tmp   <= r_head;
                        r_state <= S_INS_LINK;
                    end else begin
                        r_node  <= r_head;
                        r_steps <= IDX_W'(w_rpos_x - CMP_W'(2));
                        r_state <= S_WALK_A;
                    end
                end
                // walk along the list: wait for the link, then follow it
                S_WALK_A: begin
                    if (r_steps == '0) begin
                        r_state <= S_AT;
                    end else begin
                        r_state <= S_WALK_B;
                    end
                end
                S_WALK_B: begin
                    r_node  <= w_link;
                    r_steps <= r_steps - IDX_W'(1);
                    r_state <= S_WALK_A;
                end
                // target reached, both stores show its entry
                S_AT: begin
                    case (r_op)
                        OP_INSERT: begin
                            r_tmp   <= w_link;
                            r_state <= S_INS_LINK;
                        end
                        OP_DELETE: begin
                            r_prev  <= r_node;
                            r_node  <= w_link;
                            r_state <= S_DEL_A;
                        end
                        OP_GET: begin
                            r_rval  <= i_value_q;
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                // new node takes over the old successor
                S_INS_LINK: begin
                    if (r_pos == 8'd1) begin
                        r_head <= r_new;
                    end
                    r_cnt   <= r_cnt + IDX_W'(1);
                    r_state <= S_DONE;
                end
                // wait for the removed node's entry
                S_DEL_A: begin
                    r_state <= S_DEL_B;
                end
                // unlink the node and keep its value
                S_DEL_B: begin
                    r_rval <= i_value_q;
                    if (r_pos == 8'd1) begin
                        r_head <= w_link;
                    end
                    r_state <= S_DEL_C;
                end
                // push the node onto the free list
                S_DEL_C: begin
                    r_free  <= r_node;
                    r_fcnt  <= r_fcnt + IDX_W'(1);
                    r_cnt   <= r_cnt - IDX_W'(1);
                    r_state <= S_DONE;
                end
                // search, one entry after another from the head
                S_LOC_A: begin
                    if ((r_node == '0) || (r_k > r_cnt)) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_LOC_B;
                    end
                end
                S_LOC_B: begin
                    if (i_value_q == r_val) begin
                        r_fpos  <= r_k;
                        r_state <= S_DONE;
                    end else begin
                        r_node  <= w_link;
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_LOC_A;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result word
    assign w_rval_ext = 64'(r_rval);
    assign w_fpos_x   = CMP_W'(r_fpos);

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.status         = r_status;
    assign o_res.result_value   = w_rval_ext[31:0];
    assign o_res.found_position = w_fpos_x[7:0];
    assign o_res.list_length    = w_cnt_x[7:0];

endmodule

[hw/rtl/sll_out.sv]
`timescale 1ns / 1ps

module sll_out
    import sll_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    output logic                 o_res_ready,
    input  t_result              i_res,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // result_value [31:0], found_position [39:32], list_length [47:40]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // status [1:0]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    logic    r_valid;
    t_result r_res;

    assign o_res_ready = !r_valid || i_m_axis_tready;

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid && o_res_ready) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res_valid && o_res_ready) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_res.list_length, r_res.found_position, r_res.result_value};
    assign o_m_axis_tuser  = r_res.status;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

import sll_pkg::*;

// tracks the list as it should look and the result words still owed by the engine
class list_checker;
    localparam int CAPACITY = NODES_DEF - 2;

    logic [31:0] entries[$];      // list contents, head first
    t_result     owed_results[$];
    int          mismatches;
    int          checked;
    int          longest;
    int          full_refusals;
    int          bad_positions;
    int          locate_hits;

    // work out the result of one accepted request and update the list
    function void note_request(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
        t_result r;
        int      p;
        int      k;
        r = '0;
        r.status = ST_OK;
        p = pos;
        case (op)
            OP_INSERT: begin
                if (p < 1 || p > entries.size() + 1) begin
                    r.status = ST_BADPOS;
                end else if (entries.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (p == entries.size() + 1) begin
                    entries.push_back(val);
                end else begin
                    entries.insert(p - 1, val);
                end
            end
            OP_DELETE: begin
                if (p < 1 || p > entries.size()) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.result_value = entries[p - 1];
                    entries.delete(p - 1);
                end
            end
            OP_GET: begin
                if (p < 1 || p > entries.size())
                    r.status = ST_BADPOS;
                else
                    r.result_value = entries[p - 1];
            end
            OP_LOCATE: begin
                // first match wins
                r.status = ST_NOTFOUND;
                for (k = 0; k < entries.size() && r.status == ST_NOTFOUND; k++) begin
                    if (entries[k] == val) begin
                        r.status = ST_OK;
                        r.found_position = 8'(k + 1);
                    end
                end
            end
            OP_CLEAR: begin
                entries.delete();
            end
            default: ;  // unused codes leave everything alone
        endcase
        r.list_length = 8'(entries.size());
        if (entries.size() > longest)
            longest = entries.size();
        if (r.status == ST_FULL)
            full_refusals++;
        if (r.status == ST_BADPOS)
            bad_positions++;
        if (op == OP_LOCATE && r.status == ST_OK)
            locate_hits++;
        owed_results.push_back(r);
    endfunction

    function void compare(string what, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // compare one result word with the oldest owed result
    function void check_result(t_result got);
        t_result want;
        if (owed_results.size() == 0) begin
            $display("%0t: result word with nothing owed, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
        end
        want = owed_results.pop_front();
        checked++;
        compare("status", 32'(want.status), 32'(got.status));
        compare("result_value", want.result_value, got.result_value);
        compare("found_position", 32'(want.found_position), 32'(got.found_position));
        compare("list_length", 32'(want.list_length), 32'(got.list_length));
    endfunction
endclass

module tb_top;

    localparam int CAPACITY     = NODES_DEF - 2;
    localparam int RANDOM_ITEMS = 1780;
    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_WAIT  = 600;

    // operation mix of a random stretch
    typedef enum int {
        FILL_UP,
        CHURN,
        DRAIN
    } t_mix;

    logic                 i_clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic [S_TUSER_W-1:0] s_user = '0;
    logic                 m_ready = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [M_TDATA_W-1:0] m_data;
    logic [M_TUSER_W-1:0] m_user;

    list_checker sb = new();

    int burst_left = 1;
    int n_sent = 0;
    int quiet_cycles = 0;
    int recv_mode = 0;
    int recv_cycle = 0;

    logic [31:0] corner_values [8] = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000,
                                       32'h7fff_ffff, 32'h0000_0001, 32'h0000_0005,
                                       32'h1234_5678, 32'hdead_beef};

    static_linked_list_engine DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always #5 i_clk = ~i_clk;

    // receiver stalls, in one of four patterns picked at random
    always @(posedge i_clk) begin
        recv_cycle++;
        if (recv_cycle % 256 == 0)
            recv_mode = $urandom_range(0, 3);
        case (recv_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= (recv_cycle % 8) < 3;
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // result word monitor
    always @(posedge i_clk) begin
        t_result got;
        if (rst_n && m_valid && m_ready) begin
            got.status         = t_status'(m_user[1:0]);
            got.result_value   = m_data[31:0];
            got.found_position = m_data[39:32];
            got.list_length    = m_data[47:40];
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // hand one request word to the engine, then maybe pause the sender
    task automatic send_word(input logic [2:0] op, input logic [7:0] pos,
                             input logic [31:0] val);
        s_valid <= 1'b1;
        s_data  <= {val, pos};
        s_user  <= op;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_request(op, pos, val);
        n_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(4, 24)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // random requests; fill-up and drain stretches run until the list is full or
    // empty and then go on for extra more words, churn just runs extra words
    task automatic run_random(input t_mix mix, input int extra);
        int          left;
        int          r;
        int          len;
        int          limit;
        int          w_ins;
        int          w_del;
        int          w_get;
        int          w_loc;
        int          w_clr;
        bit          reached;
        logic [2:0]  op;
        logic [7:0]  pos;
        logic [31:0] val;
        left = extra;
        reached = (mix == CHURN);
        case (mix)
            FILL_UP: begin
                w_ins = 80; w_del = 85; w_get = 92; w_loc = 98; w_clr = 98;
            end
            DRAIN: begin
                w_ins = 15; w_del = 70; w_get = 85; w_loc = 97; w_clr = 97;
            end
            default: begin
                w_ins = 35; w_del = 60; w_get = 78; w_loc = 95; w_clr = 97;
            end
        endcase
        while (left > 0) begin
            len = sb.entries.size();
            r = $urandom_range(0, 99);
            if (r < w_ins)
                op = OP_INSERT;
            else if (r < w_del)
                op = OP_DELETE;
            else if (r < w_get)
                op = OP_GET;
            else if (r < w_loc)
                op = OP_LOCATE;
            else if (r < w_clr)
                op = OP_CLEAR;
            else
                op = 3'($urandom_range(5, 7));
            // mostly legal positions, a few anywhere in the field
            limit = (op == OP_INSERT) ? len + 1 : len;
            if (limit == 0 || $urandom_range(0, 99) < 8)
                pos = 8'($urandom_range(0, 255));
            else
                pos = 8'($urandom_range(1, limit));
            // locate usually searches for something on the list
            if (op == OP_LOCATE && len > 0 && $urandom_range(0, 99) < 60)
                val = sb.entries[$urandom_range(0, len - 1)];
            else if ($urandom_range(0, 1) == 0)
                val = corner_values[$urandom_range(0, 7)];
            else
                val = $urandom;
            send_word(op, pos, val);
            if (!reached)
                reached = (mix == FILL_UP) ? (sb.entries.size() == CAPACITY)
                                           : (sb.entries.size() == 0);
            if (reached)
                left--;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list: every positional request is refused, locate misses
        send_word(OP_GET, 8'd1, 32'h0);
        send_word(OP_DELETE, 8'd1, 32'h0);
        send_word(OP_LOCATE, 8'd0, 32'h0);
        send_word(OP_INSERT, 8'd0, 32'h1);
        send_word(OP_INSERT, 8'd2, 32'h1);
        // build a short list at head, tail and middle with extreme values
        send_word(OP_INSERT, 8'd1, 32'h8000_0000);
        send_word(OP_INSERT, 8'd2, 32'h7fff_ffff);
        send_word(OP_INSERT, 8'd1, 32'hffff_ffff);
        send_word(OP_INSERT, 8'd2, 32'h0000_0000);
        send_word(OP_INSERT, 8'd5, 32'h5a5a_a5a5);
        send_word(OP_INSERT, 8'd255, 32'h1);
        // reads at both ends and past the end
        send_word(OP_GET, 8'd1, 32'h0);
        send_word(OP_GET, 8'd5, 32'h0);
        send_word(OP_GET, 8'd6, 32'h0);
        send_word(OP_GET, 8'd255, 32'hffff_ffff);
        // locate hits deep and at the head, then a miss
        send_word(OP_LOCATE, 8'd0, 32'h7fff_ffff);
        send_word(OP_LOCATE, 8'd255, 32'hffff_ffff);
        send_word(OP_LOCATE, 8'd0, 32'h0000_0001);
        // deletes: bad position, middle, tail, head
        send_word(OP_DELETE, 8'd0, 32'h0);
        send_word(OP_DELETE, 8'd3, 32'h0);
        send_word(OP_DELETE, 8'd4, 32'h0);
        send_word(OP_DELETE, 8'd1, 32'h0);
        // unused codes do nothing
        send_word(3'd5, 8'd1, 32'h0);
        send_word(3'd6, 8'd255, 32'hffff_ffff);
        send_word(3'd7, 8'd2, 32'h8000_0000);
        // clear and reuse
        send_word(OP_CLEAR, 8'd0, 32'h0);
        send_word(OP_GET, 8'd1, 32'h0);
        send_word(OP_INSERT, 8'd1, 32'hcafe_f00d);

        run_random(CHURN, 350);
        run_random(FILL_UP, 40);
        run_random(CHURN, 300);
        run_random(DRAIN, 20);
        run_random(CHURN, RANDOM_ITEMS - n_sent);

        s_valid <= 1'b0;
        while (sb.owed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Sent %0d request words, checked %0d result words, longest list %0d of %0d.",
                 n_sent, sb.checked, sb.longest, CAPACITY);
        $display("Saw %0d full-store refusals, %0d bad positions, %0d locate hits.",
                 sb.full_refusals, sb.bad_positions, sb.locate_hits);
        if (sb.mismatches == 0 && sb.owed_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sll_pkg.sv
hw/rtl/sll_ram.sv
hw/rtl/sll_seq.sv
hw/rtl/sll_out.sv
hw/rtl/static_linked_list_engine.sv
sim/tb_top.sv
